[src/skvt_pkg.sv]
package skvt_pkg;

  localparam int CapacityDefault = 16;

  localparam int CmdW    = 3;
  localparam int KeyW    = 32;
  localparam int ValueW  = 8;
  localparam int StatusW = 2;
  localparam int EntriesW = 5;

  localparam logic [CmdW-1:0] CMD_INSERT = 3'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 3'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CmdW-1:0] CMD_DUMP   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_ABSENT = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_UPDATE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    logic     scan;
  } cell_ctl_t;

endpackage

[src/skvt_cell.sv]
module skvt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  skvt_pkg::cell_ctl_t       ctl,
  input  logic [skvt_pkg::KeyW-1:0]   cmp_key,
  input  logic [skvt_pkg::ValueW-1:0] new_value,
  input  logic                      occupied,
  input  logic                      tail,
  input  logic                      lt_in,
  input  logic [skvt_pkg::KeyW-1:0]   left_key,
  input  logic [skvt_pkg::ValueW-1:0] left_value,
  input  logic [skvt_pkg::KeyW-1:0]   right_key,
  input  logic [skvt_pkg::ValueW-1:0] right_value,
  input  logic [skvt_pkg::KeyW-1:0]   head_key,
  input  logic [skvt_pkg::ValueW-1:0] head_value,
  input  logic                      hit_in,
  input  logic [skvt_pkg::ValueW-1:0] hit_value_in,
  output logic                      lt,
  output logic [skvt_pkg::KeyW-1:0]   key,
  output logic [skvt_pkg::ValueW-1:0] value,
  output logic                      hit,
  output logic [skvt_pkg::ValueW-1:0] hit_value
);
  import skvt_pkg::*;

  logic eq;

  assign lt = occupied && (key < cmp_key);
  assign eq = occupied && (key == cmp_key);

  // search wave: hit and its value move one cell per cycle toward the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.scan) begin
      hit <= hit_in | eq;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      hit_value <= eq ? value : hit_value_in;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_UPDATE: begin
        if (eq) begin
          value <= new_value;
        end
      end
      CELL_INSERT: begin
        // cells below the slot keep, the slot takes the new entry, the rest move up
        if (!lt) begin
          if (lt_in) begin
            key   <= cmp_key;
            value <= new_value;
          end else begin
            key   <= left_key;
            value <= left_value;
          end
        end
      end
      CELL_REMOVE: begin
        if (!lt) begin
          key   <= right_key;
          value <= right_value;
        end
      end
      CELL_ROTATE: begin
        if (tail) begin
          key   <= head_key;
          value <= head_value;
        end else begin
          key   <= right_key;
          value <= right_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/sorted_key_value_table.sv]
// channel   signals                          direction  beat
// command   cmd_valid cmd_stall cmd key value  in         one command
// result    res_valid res_stall status existed out        one result
//           data entries last
//
// Insert, remove and lookup run a search wave that crosses the chain one cell
// per cycle, then a finishing step shifts or updates the cells as needed.
// Clear goes straight to the finishing step; a dump gives one beat per entry.
// rst is synchronous and empties the table. A result stall holds the
// finishing step or the dump rotation until the result register frees up.
module sorted_key_value_table #(
  parameter int CAPACITY = skvt_pkg::CapacityDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [skvt_pkg::CmdW-1:0]    cmd,
  input  logic [skvt_pkg::KeyW-1:0]    key,
  input  logic [skvt_pkg::ValueW-1:0]  value,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [skvt_pkg::StatusW-1:0] status,
  output logic                         existed,
  output logic [skvt_pkg::ValueW-1:0]  data,
  output logic [skvt_pkg::EntriesW-1:0] entries,
  output logic                         last
);
  import skvt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] scan_cnt;
  logic [CW-1:0] dump_idx;
  logic [CmdW-1:0]   cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [ValueW-1:0] value_q;

  cell_ctl_t ctl;
  logic accept, res_free, res_load, dump_end;
  logic [StatusW-1:0] status_w;
  logic existed_w, last_w;
  logic [ValueW-1:0] data_w;

  logic [KeyW-1:0]   cell_key   [CAPACITY];
  logic [ValueW-1:0] cell_value [CAPACITY];
  logic              cell_lt    [CAPACITY];
  logic              cell_hit   [CAPACITY];
  logic [ValueW-1:0] cell_hval  [CAPACITY];

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;
  assign dump_end  = (count == '0) || ((dump_idx + CW'(1)) == count);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      skvt_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctl          (ctl),
        .cmp_key      (key_q),
        .new_value    (value_q),
        .occupied     (CW'(i) < count),
        .tail         (count == CW'(i + 1)),
        .lt_in        ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
        .left_key     (cell_key[(i == 0) ? 0 : i - 1]),
        .left_value   (cell_value[(i == 0) ? 0 : i - 1]),
        .right_key    (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
        .right_value  (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
        .head_key     (cell_key[0]),
        .head_value   (cell_value[0]),
        .hit_in       ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i - 1]),
        .hit_value_in ((i == 0) ? '0 : cell_hval[(i == 0) ? 0 : i - 1]),
        .lt           (cell_lt[i]),
        .key          (cell_key[i]),
        .value        (cell_value[i]),
        .hit          (cell_hit[i]),
        .hit_value    (cell_hval[i])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_INSERT, CMD_REMOVE, CMD_LOOKUP: state_next = S_SCAN;
            CMD_CLEAR:                          state_next = S_FINISH;
            CMD_DUMP:                           state_next = S_DUMP;
            default:                            state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_cnt == SW'(CAPACITY - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (res_free && dump_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.scan   = 1'b0;
    res_load   = 1'b0;
    status_w   = ST_OK;
    existed_w  = 1'b0;
    data_w     = '0;
    last_w     = 1'b1;
    count_next = count;
    unique case (state)
      S_IDLE: begin
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
      end
      S_FINISH: begin
        if (res_free) begin
          res_load = 1'b1;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (cell_hit[CAPACITY-1]) begin
                ctl.op    = CELL_UPDATE;
                existed_w = 1'b1;
              end else if (count == CW'(CAPACITY)) begin
                status_w = ST_FULL;
              end else begin
                ctl.op     = CELL_INSERT;
                count_next = count + CW'(1);
              end
            end
            CMD_REMOVE: begin
              if (cell_hit[CAPACITY-1]) begin
                ctl.op     = CELL_REMOVE;
                existed_w  = 1'b1;
                data_w     = cell_hval[CAPACITY-1];
                count_next = count - CW'(1);
              end else begin
                status_w = ST_ABSENT;
              end
            end
            CMD_LOOKUP: begin
              if (cell_hit[CAPACITY-1]) begin
                existed_w = 1'b1;
                data_w    = cell_hval[CAPACITY-1];
              end else begin
                status_w = ST_ABSENT;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (res_free) begin
          res_load = 1'b1;
          if (count == '0) begin
            status_w = ST_ABSENT;
          end else begin
            // rotate the live entries so the next one sits in cell 0
            ctl.op = CELL_ROTATE;
            data_w = cell_value[0];
            last_w = dump_end;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      dump_idx <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + SW'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (state == S_DUMP) begin
        if (res_load) begin
          dump_idx <= dump_idx + CW'(1);
        end
      end else begin
        dump_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      key_q   <= key;
      value_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status  <= status_w;
      existed <= existed_w;
      data    <= data_w;
      entries <= EntriesW'(count_next);
      last    <= last_w;
    end
  end

endmodule

[tb/sorted_key_value_table_tb.sv]
module sorted_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skvt_pkg::*;

  localparam int Capacity     = CapacityDefault;
  localparam int CmdMax       = (1 << CmdW) - 1;
  localparam int IdlePct      = 31;
  localparam int SettleCycles = 2 * Capacity + 8;
  localparam int CycleLimit   = 200000;
  localparam int ReportMax    = 10;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic                existed;
    logic [ValueW-1:0]   data;
    logic [EntriesW-1:0] entries;
    logic                last;
  } table_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic [CmdW-1:0]     cmd = '0;
  logic [KeyW-1:0]     key = '0;
  logic [ValueW-1:0]   value = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [StatusW-1:0]  status;
  logic                existed;
  logic [ValueW-1:0]   data;
  logic [EntriesW-1:0] entries;
  logic                last;

  // shadow copy of the table contents
  logic [KeyW-1:0]   shadow_keys [Capacity];
  logic [ValueW-1:0] shadow_vals [Capacity];
  int                shadow_count = 0;

  table_reply_t pending_replies[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           idle_enable = 1'b0;
  bit           stall_enable = 1'b0;

  sorted_key_value_table #(.CAPACITY(Capacity)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .key(key),
    .value(value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .existed(existed),
    .data(data),
    .entries(entries),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sorted_key_value_table regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_stall <= stall_enable && ($urandom_range(0, 99) < IdlePct);
  end

  function automatic void push_reply(input logic [StatusW-1:0] st, input logic ex,
                                     input logic [ValueW-1:0] d, input logic lst);
    table_reply_t r;
    r.status  = st;
    r.existed = ex;
    r.data    = d;
    r.entries = EntriesW'(shadow_count);
    r.last    = lst;
    pending_replies.push_back(r);
  endfunction

  // updates the shadow table and queues the beats the command should produce
  function automatic void apply_command(input logic [CmdW-1:0] op, input logic [KeyW-1:0] k,
                                        input logic [ValueW-1:0] v);
    int pos;
    bit hit;
    logic [ValueW-1:0] old;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < k) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == k);
    case (op)
      CMD_INSERT: begin
        if (hit) begin
          shadow_vals[pos] = v;
          push_reply(ST_OK, 1'b1, '0, 1'b1);
        end else if (shadow_count >= Capacity) begin
          push_reply(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[pos] = k;
          shadow_vals[pos] = v;
          shadow_count++;
          push_reply(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          old = shadow_vals[pos];
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_count--;
          push_reply(ST_OK, 1'b1, old, 1'b1);
        end else begin
          push_reply(ST_ABSENT, 1'b0, '0, 1'b1);
        end
      end
      CMD_LOOKUP: begin
        if (hit) push_reply(ST_OK, 1'b1, shadow_vals[pos], 1'b1);
        else push_reply(ST_ABSENT, 1'b0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        push_reply(ST_OK, 1'b0, '0, 1'b1);
      end
      CMD_DUMP: begin
        if (shadow_count == 0) begin
          push_reply(ST_ABSENT, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            push_reply(ST_OK, 1'b0, shadow_vals[i], i + 1 == shadow_count);
        end
      end
      default: ;  // undefined codes are dropped
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    table_reply_t got;
    table_reply_t want;
    if (!rst && res_valid && !res_stall) begin
      got.status  = status;
      got.existed = existed;
      got.data    = data;
      got.entries = entries;
      got.last    = last;
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax)
          $display("%0t: unexpected result beat status=%0d existed=%0d data=%02h entries=%0d last=%0d",
                   $realtime, got.status, got.existed, got.data, got.entries, got.last);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.existed !== want.existed ||
            got.data !== want.data || got.entries !== want.entries || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected status=%0d existed=%0d data=%02h entries=%0d last=%0d",
                     want.status, want.existed, want.data, want.entries, want.last);
            $display("  actual   status=%0d existed=%0d data=%02h entries=%0d last=%0d",
                     got.status, got.existed, got.data, got.entries, got.last);
          end
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_command(input logic [CmdW-1:0] op, input logic [KeyW-1:0] k,
                              input logic [ValueW-1:0] v);
    while (idle_enable && $urandom_range(0, 99) < IdlePct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd       = op;
    key       = k;
    value     = v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_command(op, k, v);
    @(negedge clk);
    cmd_valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_command(CMD_DUMP, $urandom, 8'h00);           // dump of empty table
    send_command(CMD_LOOKUP, 32'h0000_1234, 8'h00);
    send_command(CMD_REMOVE, 32'h0000_0000, 8'h00);
    send_command(CMD_INSERT, 32'h0000_0000, 8'h00);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_INSERT, 32'h8000_0000, 8'h80);
    send_command(CMD_INSERT, 32'h7FFF_FFFF, 8'h7F);    // lands mid-table, shifts upper half
    send_command(CMD_INSERT, 32'h0000_0000, 8'h5A);    // update in place
    send_command(CMD_LOOKUP, 32'h0000_0000, 8'h00);
    send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    send_command(CMD_LOOKUP, 32'h0000_0001, 8'h00);
    send_command(CMD_DUMP, 32'h0000_0000, 8'h00);
    for (int c = int'(CMD_DUMP) + 1; c <= CmdMax; c++)
      send_command(CmdW'(c), 32'h8000_0000, 8'hAA);
    send_command(CMD_REMOVE, 32'h8000_0000, 8'h00);
    send_command(CMD_REMOVE, 32'h8000_0000, 8'h00);
    send_command(CMD_REMOVE, 32'hFFFF_FFFF, 8'h00);
    send_command(CMD_DUMP, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_CLEAR, 32'h0000_0000, 8'h00);
    send_command(CMD_DUMP, 32'h0000_0000, 8'h00);
    send_command(CMD_LOOKUP, 32'h0000_0000, 8'h00);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_fill_to_capacity();
    int idx;
    send_command(CMD_CLEAR, $urandom, 8'($urandom_range(0, 255)));
    while (shadow_count < Capacity)
      send_command(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
    send_command(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));  // refused
    idx = $urandom_range(0, Capacity - 1);
    send_command(CMD_INSERT, shadow_keys[idx], 8'($urandom_range(0, 255)));
    send_command(CMD_LOOKUP, shadow_keys[idx], 8'($urandom_range(0, 255)));
    send_command(CMD_DUMP, $urandom, 8'($urandom_range(0, 255)));
    send_command(CMD_REMOVE, shadow_keys[0], 8'($urandom_range(0, 255)));
    send_command(CMD_REMOVE, shadow_keys[shadow_count-1], 8'($urandom_range(0, 255)));
    send_command(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
    send_command(CMD_DUMP, $urandom, 8'($urandom_range(0, 255)));
  endtask

  // keys mostly come from a small pool so hits, updates and full-table refusals are common
  task automatic test_random_traffic(input int count);
    logic [KeyW-1:0] key_pool [20];
    logic [KeyW-1:0] k;
    logic [CmdW-1:0] op;
    int pick;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 20; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, 19)];
      else k = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = CMD_INSERT;
      else if (pick < 65) op = CMD_REMOVE;
      else if (pick < 82) op = CMD_LOOKUP;
      else if (pick < 90) op = CMD_DUMP;
      else if (pick < 92) op = CMD_CLEAR;
      else op = CmdW'($urandom_range(int'(CMD_DUMP) + 1, CmdMax));
      send_command(op, k, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_enable  = 1'b1;
    stall_enable = 1'b1;
    test_directed();

    // back-to-back stretch, no gaps on either side
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    test_fill_to_capacity();

    idle_enable  = 1'b1;
    stall_enable = 1'b1;
    wait_for_drain();
    test_random_traffic(120);
    wait_for_drain();
    test_random_traffic(100);
    test_fill_to_capacity();
    wait_for_drain();

    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("sorted_key_value_table regression: pass");
    end else begin
      $display("sorted_key_value_table regression: fail");
    end
    $finish;
  end

endmodule
